// ===== design/ffra_pkg.sv =====
// Shared types and codes of the first-fit range allocator.
// No dependencies; used by ffra_cell and first_fit_range_allocator_core.
`default_nettype none

package ffra_pkg;

    // width of a cell position on the control bus (up to 256 cells)
    localparam int POS_W = 8;

    // request opcodes
    typedef enum logic {
        CMD_ALLOC = 1'b0,
        CMD_FREE  = 1'b1
    } cmd_t;

    // result status codes
    localparam logic [1:0] STATUS_OK   = 2'd0;
    localparam logic [1:0] STATUS_MAX  = 2'd1;
    localparam logic [1:0] STATUS_FULL = 2'd2;

    // configuration register indexes
    localparam logic [1:0] CFG_INITIAL_UNITS  = 2'd0;
    localparam logic [1:0] CFG_GROW_MIN_UNITS = 2'd1;
    localparam logic [1:0] CFG_MAX_UNITS      = 2'd2;

    // reset values
    localparam logic [31:0] RESET_INITIAL_UNITS = 32'd65536;
    localparam logic [31:0] RESET_GROW_MIN      = 32'd65536;
    localparam logic [31:0] RESET_MAX_UNITS     = 32'hFFFF_FFFF;

    typedef struct packed {
        logic        cmd;
        logic [31:0] unit_count;
        logic [31:0] free_offset;
    } req_t;

    typedef struct packed {
        logic [31:0] alloc_offset;
        logic [1:0]  status;
        logic        grew;
        logic [31:0] capacity;
        logic [31:0] free_total;
    } resp_t;

    // one hole [hs, he)
    typedef struct packed {
        logic [31:0] hs;
        logic [31:0] he;
    } hole_t;

    // cell operations
    typedef enum logic [2:0] {
        CELL_HOLD = 3'd0,
        CELL_ROT  = 3'd1,
        CELL_DEL  = 3'd2,
        CELL_INS  = 3'd3,
        CELL_WR   = 3'd4
    } cell_op_t;

    typedef struct packed {
        cell_op_t         op;
        logic [POS_W-1:0] pos;
        hole_t            wdata;
    } cell_ctl_t;

endpackage

`default_nettype wire

// ===== design/ffra_cell.sv =====
// One cell of the hole chain: holds a single hole and trades it with its neighbors.
// Depends on ffra_pkg.
`default_nettype none

module ffra_cell #(
    parameter int IDX = 0
) (
    input  wire                      aclk,
    input  wire ffra_pkg::cell_ctl_t ctl,
    input  wire ffra_pkg::hole_t     right_in,
    input  wire ffra_pkg::hole_t     left_in,
    output ffra_pkg::hole_t          hole_out
);

    localparam logic [ffra_pkg::POS_W-1:0] MY_POS = ffra_pkg::POS_W'(IDX);

    ffra_pkg::hole_t hole_reg;
    ffra_pkg::hole_t hole_next;

    // next content by chain operation
    always_comb begin
        hole_next = hole_reg;
        case (ctl.op)
            ffra_pkg::CELL_ROT: begin
                hole_next = right_in;
            end
            ffra_pkg::CELL_DEL: begin
                if (MY_POS >= ctl.pos) begin
                    hole_next = right_in;
                end
            end
            ffra_pkg::CELL_INS: begin
                if (MY_POS > ctl.pos) begin
                    hole_next = left_in;
                end else if (MY_POS == ctl.pos) begin
                    hole_next = ctl.wdata;
                end
            end
            ffra_pkg::CELL_WR: begin
                if (MY_POS == ctl.pos) begin
                    hole_next = ctl.wdata;
                end
            end
            default: begin
                hole_next = hole_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        hole_reg <= hole_next;
    end

    assign hole_out = hole_reg;

endmodule

`default_nettype wire

// ===== design/first_fit_range_allocator_core.sv =====
// First-fit range allocator: a chain of hole cells plus the scan and update control.
// Depends on ffra_pkg and ffra_cell.
`default_nettype none

// Allocates and frees unit ranges. An allocate that fits the bump region, and a
// free that is empty after clipping at the bump pointer, go from ST_IDLE straight
// to ST_OUT. Everything else rotates the whole hole chain once past the scan unit
// at cell 0 in ST_SCAN, applies the outcome in ST_DECIDE and, in ST_SHIFT, deletes
// each extra hole that a free swallows when it coalesces. Holes are kept sorted
// by start in cells 0 .. count-1. A new request is taken while the previous
// result still waits in the output register. Configuration writes are accepted
// in any cycle; writing initial_units empties the allocator.
module first_fit_range_allocator_core #(
    parameter int HOLE_SLOTS = 16
) (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  wire                 cfg_we,
    input  wire  [1:0]          cfg_index,
    input  wire  [31:0]         cfg_wdata,
    input  wire                 s_valid,
    output logic                s_ready,
    input  wire ffra_pkg::req_t s_data,
    output logic                m_valid,
    input  wire                 m_ready,
    output ffra_pkg::resp_t     m_data
);

    localparam int IW = (HOLE_SLOTS > 1) ? $clog2(HOLE_SLOTS) : 1;
    localparam int CW = $clog2(HOLE_SLOTS + 1);
    localparam logic [IW-1:0] LAST_T = IW'(HOLE_SLOTS - 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(HOLE_SLOTS);

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_SCAN   = 5'b00010,
        ST_DECIDE = 5'b00100,
        ST_SHIFT  = 5'b01000,
        ST_OUT    = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    logic [31:0] grow_min_reg, grow_min_next;
    logic [31:0] max_reg, max_next;
    logic [31:0] bump_reg, bump_next;
    logic [31:0] end_reg, end_next;
    logic [31:0] sum_reg, sum_next;
    logic [CW-1:0] count_reg, count_next;

    logic        cmd_reg, cmd_next;
    logic [31:0] cnt_reg, cnt_next;
    logic [31:0] lo_reg, lo_next;
    logic [31:0] hi_reg, hi_next;
    logic [IW-1:0] t_reg, t_next;
    logic        found_reg, found_next;
    logic [IW-1:0] hit_idx_reg, hit_idx_next;
    ffra_pkg::hole_t hit_reg, hit_next;
    logic [31:0] ns_reg, ns_next;
    logic [31:0] ne_reg, ne_next;
    logic [CW-1:0] k_reg, k_next;
    logic [IW-1:0] a_reg, a_next;
    logic [CW-1:0] p_reg, p_next;
    logic [31:0] delsum_reg, delsum_next;
    logic [CW-1:0] del_left_reg, del_left_next;

    logic [31:0] res_off_reg, res_off_next;
    logic [1:0]  res_status_reg, res_status_next;
    logic        res_grew_reg, res_grew_next;
    logic        m_valid_reg, m_valid_next;
    ffra_pkg::resp_t m_data_reg, m_data_next;

    ffra_pkg::cell_ctl_t ctl;
    ffra_pkg::hole_t cell_q [HOLE_SLOTS];

    // hole chain
    genvar gi;
    generate
        for (gi = 0; gi < HOLE_SLOTS; gi++) begin : g_cell
            ffra_cell #(
                .IDX(gi)
            ) u_cell (
                .aclk    (aclk),
                .ctl     (ctl),
                .right_in(cell_q[(gi + 1) % HOLE_SLOTS]),
                .left_in (cell_q[(gi + HOLE_SLOTS - 1) % HOLE_SLOTS]),
                .hole_out(cell_q[gi])
            );
        end
    endgenerate

    // scan unit signals
    ffra_pkg::hole_t head;
    logic        in_range;
    logic [31:0] head_len;
    logic        touch;
    logic [31:0] remaining;
    logic [32:0] free_hi33;
    logic [31:0] free_hi;
    logic [31:0] step;
    logic [32:0] new_end33;
    logic [31:0] new_start;
    logic        absorb;
    logic [32:0] total33;

    assign head      = cell_q[0];
    assign in_range  = CW'(t_reg) < count_reg;
    assign head_len  = head.he - head.hs;
    assign touch     = in_range && (head.hs <= hi_reg) && (lo_reg <= head.he);
    assign remaining = (end_reg > bump_reg) ? (end_reg - bump_reg) : 32'd0;
    assign free_hi33 = {1'b0, s_data.free_offset} + {1'b0, s_data.unit_count};
    assign free_hi   = (free_hi33 > {1'b0, bump_reg}) ? bump_reg : free_hi33[31:0];
    assign step      = (cnt_reg > grow_min_reg) ? cnt_reg : grow_min_reg;
    assign new_end33 = {1'b0, end_reg} + {1'b0, step};
    assign new_start = hit_reg.hs + cnt_reg;
    assign absorb    = ne_reg >= bump_reg;
    assign total33   = {1'b0, remaining} + {1'b0, sum_reg};

    // control and datapath next state
    always_comb begin
        state_next      = state_reg;
        grow_min_next   = grow_min_reg;
        max_next        = max_reg;
        bump_next       = bump_reg;
        end_next        = end_reg;
        sum_next        = sum_reg;
        count_next      = count_reg;
        cmd_next        = cmd_reg;
        cnt_next        = cnt_reg;
        lo_next         = lo_reg;
        hi_next         = hi_reg;
        t_next          = t_reg;
        found_next      = found_reg;
        hit_idx_next    = hit_idx_reg;
        hit_next        = hit_reg;
        ns_next         = ns_reg;
        ne_next         = ne_reg;
        k_next          = k_reg;
        a_next          = a_reg;
        p_next          = p_reg;
        delsum_next     = delsum_reg;
        del_left_next   = del_left_reg;
        res_off_next    = res_off_reg;
        res_status_next = res_status_reg;
        res_grew_next   = res_grew_reg;
        m_data_next     = m_data_reg;
        m_valid_next    = (m_valid_reg && m_ready) ? 1'b0 : m_valid_reg;
        ctl.op          = ffra_pkg::CELL_HOLD;
        ctl.pos         = '0;
        ctl.wdata       = '0;

        case (state_reg)
            // take a request, serve the quick cases at once
            ST_IDLE: begin
                if (s_valid) begin
                    cmd_next        = s_data.cmd;
                    cnt_next        = s_data.unit_count;
                    lo_next         = s_data.free_offset;
                    hi_next         = free_hi;
                    t_next          = '0;
                    found_next      = 1'b0;
                    k_next          = '0;
                    p_next          = '0;
                    delsum_next     = '0;
                    ns_next         = s_data.free_offset;
                    ne_next         = free_hi;
                    res_off_next    = '0;
                    res_status_next = ffra_pkg::STATUS_OK;
                    res_grew_next   = 1'b0;
                    if (s_data.cmd == ffra_pkg::CMD_ALLOC) begin
                        if (s_data.unit_count <= remaining) begin
                            res_off_next = bump_reg;
                            bump_next    = bump_reg + s_data.unit_count;
                            state_next   = ST_OUT;
                        end else begin
                            state_next = ST_SCAN;
                        end
                    end else if (free_hi <= s_data.free_offset) begin
                        state_next = ST_OUT;
                    end else begin
                        state_next = ST_SCAN;
                    end
                end
            end

            // rotate the chain once past cell 0
            ST_SCAN: begin
                ctl.op = ffra_pkg::CELL_ROT;
                if (cmd_reg == ffra_pkg::CMD_ALLOC) begin
                    if (in_range && !found_reg && (head_len >= cnt_reg)) begin
                        found_next   = 1'b1;
                        hit_idx_next = t_reg;
                        hit_next     = head;
                    end
                end else begin
                    if (touch) begin
                        if (k_reg == '0) begin
                            a_next = t_reg;
                        end
                        if (head.hs < ns_reg) begin
                            ns_next = head.hs;
                        end
                        if (head.he > ne_reg) begin
                            ne_next = head.he;
                        end
                        k_next      = k_reg + CW'(1);
                        delsum_next = delsum_reg + head_len;
                    end else if (in_range && (head.hs < lo_reg)) begin
                        p_next = p_reg + CW'(1);
                    end
                end
                t_next = t_reg + IW'(1);
                if (t_reg == LAST_T) begin
                    state_next = ST_DECIDE;
                end
            end

            // apply the scan outcome
            ST_DECIDE: begin
                state_next = ST_OUT;
                if (cmd_reg == ffra_pkg::CMD_ALLOC) begin
                    if (found_reg) begin
                        res_off_next = hit_reg.hs;
                        sum_next     = sum_reg - cnt_reg;
                        ctl.pos      = ffra_pkg::POS_W'(hit_idx_reg);
                        if (new_start == hit_reg.he) begin
                            ctl.op     = ffra_pkg::CELL_DEL;
                            count_next = count_reg - CW'(1);
                        end else begin
                            ctl.op       = ffra_pkg::CELL_WR;
                            ctl.wdata.hs = new_start;
                            ctl.wdata.he = hit_reg.he;
                        end
                    end else if (new_end33 > {1'b0, max_reg}) begin
                        res_status_next = ffra_pkg::STATUS_MAX;
                    end else begin
                        end_next      = new_end33[31:0];
                        res_grew_next = 1'b1;
                        res_off_next  = bump_reg;
                        bump_next     = bump_reg + cnt_reg;
                    end
                end else begin
                    if (absorb) begin
                        // merged range reaches the bump pointer: pull it back
                        count_next = count_reg - k_reg;
                        bump_next  = ns_reg;
                        sum_next   = sum_reg - delsum_reg;
                    end else if (k_reg == '0) begin
                        if (count_reg == FULL_COUNT) begin
                            res_status_next = ffra_pkg::STATUS_FULL;
                        end else begin
                            ctl.op       = ffra_pkg::CELL_INS;
                            ctl.pos      = ffra_pkg::POS_W'(p_reg);
                            ctl.wdata.hs = lo_reg;
                            ctl.wdata.he = hi_reg;
                            count_next   = count_reg + CW'(1);
                            sum_next     = sum_reg + (hi_reg - lo_reg);
                        end
                    end else begin
                        ctl.op       = ffra_pkg::CELL_WR;
                        ctl.pos      = ffra_pkg::POS_W'(a_reg);
                        ctl.wdata.hs = ns_reg;
                        ctl.wdata.he = ne_reg;
                        count_next   = count_reg - k_reg + CW'(1);
                        sum_next     = sum_reg - delsum_reg + (ne_reg - ns_reg);
                        if (k_reg != CW'(1)) begin
                            del_left_next = k_reg - CW'(1);
                            state_next    = ST_SHIFT;
                        end
                    end
                end
            end

            // close the gap left by coalesced holes, one per cycle
            ST_SHIFT: begin
                ctl.op        = ffra_pkg::CELL_DEL;
                ctl.pos       = ffra_pkg::POS_W'(a_reg) + ffra_pkg::POS_W'(1);
                del_left_next = del_left_reg - CW'(1);
                if (del_left_reg == CW'(1)) begin
                    state_next = ST_OUT;
                end
            end

            // load the result register once it is free
            ST_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    m_data_next.alloc_offset = res_off_reg;
                    m_data_next.status       = res_status_reg;
                    m_data_next.grew         = res_grew_reg;
                    m_data_next.capacity     = end_reg;
                    m_data_next.free_total   = total33[32] ? 32'hFFFF_FFFF : total33[31:0];
                    m_valid_next             = 1'b1;
                    state_next               = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase

        // configuration writes
        if (cfg_we) begin
            case (cfg_index)
                ffra_pkg::CFG_INITIAL_UNITS: begin
                    bump_next  = '0;
                    end_next   = cfg_wdata;
                    count_next = '0;
                    sum_next   = '0;
                end
                ffra_pkg::CFG_GROW_MIN_UNITS: begin
                    grow_min_next = cfg_wdata;
                end
                ffra_pkg::CFG_MAX_UNITS: begin
                    max_next = cfg_wdata;
                end
                default: begin
                    max_next = max_reg;
                end
            endcase
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            grow_min_reg <= ffra_pkg::RESET_GROW_MIN;
            max_reg      <= ffra_pkg::RESET_MAX_UNITS;
            bump_reg     <= '0;
            end_reg      <= ffra_pkg::RESET_INITIAL_UNITS;
            sum_reg      <= '0;
            count_reg    <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            grow_min_reg <= grow_min_next;
            max_reg      <= max_next;
            bump_reg     <= bump_next;
            end_reg      <= end_next;
            sum_reg      <= sum_next;
            count_reg    <= count_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // working and payload registers
    always_ff @(posedge aclk) begin
        cmd_reg        <= cmd_next;
        cnt_reg        <= cnt_next;
        lo_reg         <= lo_next;
        hi_reg         <= hi_next;
        t_reg          <= t_next;
        found_reg      <= found_next;
        hit_idx_reg    <= hit_idx_next;
        hit_reg        <= hit_next;
        ns_reg         <= ns_next;
        ne_reg         <= ne_next;
        k_reg          <= k_next;
        a_reg          <= a_next;
        p_reg          <= p_next;
        delsum_reg     <= delsum_next;
        del_left_reg   <= del_left_next;
        res_off_reg    <= res_off_next;
        res_status_reg <= res_status_next;
        res_grew_reg   <= res_grew_next;
        m_data_reg     <= m_data_next;
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

`default_nettype wire

// ===== dv/first_fit_range_allocator_core_test.sv =====
// Testbench of first_fit_range_allocator_core: directed and random allocate and free
// traffic, checked against an in-bench model of the hole table. Depends on ffra_pkg and the core.
`timescale 1ns / 100ps

module first_fit_range_allocator_core_test;

    localparam int SLOTS = 16;

    logic              aclk = 1'b0;
    logic              aresetn = 1'b0;
    logic              cfg_we = 1'b0;
    logic [1:0]        cfg_index = ffra_pkg::CFG_INITIAL_UNITS;
    logic [31:0]       cfg_wdata = '0;
    logic              s_valid = 1'b0;
    logic              s_ready;
    ffra_pkg::req_t    s_data = '0;
    logic              m_valid;
    logic              m_ready = 1'b0;
    ffra_pkg::resp_t   m_data;

    first_fit_range_allocator_core #(.HOLE_SLOTS(SLOTS)) uut (
        .aclk(aclk), .aresetn(aresetn), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata), .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    always #1 aclk = ~aclk;

    // allocator image
    logic [31:0] grow_min, max_cap;
    logic [31:0] bump, cap_end;
    logic [31:0] hs [SLOTS];
    logic [31:0] he [SLOTS];
    int          nholes;

    ffra_pkg::resp_t pending_resp[$];
    int          errors = 0;
    bit          quiet = 1'b0;

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s: got %0h want %0h", what, got, want);
        errors++;
    endtask

    function automatic logic [31:0] free_sum();
        logic [63:0] acc;
        acc = (cap_end > bump) ? 64'(cap_end - bump) : 64'd0;
        for (int i = 0; i < nholes; i++) acc += 64'(he[i] - hs[i]);
        return (acc > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : acc[31:0];
    endfunction

    function automatic logic [31:0] grant_units(input logic [31:0] cnt,
                                                output logic [1:0] st, output logic gr);
        logic [31:0] room, off, stepsz;
        logic [63:0] ne;
        st = ffra_pkg::STATUS_OK;
        gr = 1'b0;
        room = (cap_end > bump) ? cap_end - bump : 32'd0;
        if (cnt <= room) begin
            off = bump;
            bump += cnt;
            return off;
        end
        for (int i = 0; i < nholes; i++) begin
            if (he[i] - hs[i] >= cnt) begin
                off = hs[i];
                hs[i] += cnt;
                if (hs[i] == he[i]) begin
                    for (int j = i; j + 1 < nholes; j++) begin
                        hs[j] = hs[j+1];
                        he[j] = he[j+1];
                    end
                    nholes--;
                end
                return off;
            end
        end
        stepsz = (cnt > grow_min) ? cnt : grow_min;
        ne = 64'(cap_end) + 64'(stepsz);
        if (ne > 64'(max_cap)) begin
            st = ffra_pkg::STATUS_MAX;
            return 32'd0;
        end
        cap_end = ne[31:0];
        gr = 1'b1;
        off = bump;
        bump += cnt;
        return off;
    endfunction

    function automatic logic [1:0] release_units(input logic [31:0] lo, input logic [31:0] cnt);
        logic [31:0] ts [SLOTS+1];
        logic [31:0] te [SLOTS+1];
        logic [63:0] top;
        logic [31:0] hi, nb;
        int n, m;
        bit placed;
        n = 0; m = 0; placed = 0; nb = bump;
        top = 64'(lo) + 64'(cnt);
        if (top > 64'(bump)) top = 64'(bump);
        if (top <= 64'(lo)) return ffra_pkg::STATUS_OK;
        hi = top[31:0];
        for (int k = 0; k < nholes; k++) begin
            if (!placed && lo < hs[k]) begin
                ts[n] = lo; te[n] = hi; n++; placed = 1;
            end
            ts[n] = hs[k]; te[n] = he[k]; n++;
        end
        if (!placed) begin
            ts[n] = lo; te[n] = hi; n++;
        end
        // coalesce touching or overlapping ranges
        for (int k = 0; k < n; k++) begin
            if (m > 0 && ts[k] <= te[m-1]) begin
                if (te[k] > te[m-1]) te[m-1] = te[k];
            end else begin
                ts[m] = ts[k]; te[m] = te[k]; m++;
            end
        end
        if (m > 0 && te[m-1] >= bump) begin
            nb = ts[m-1];
            m--;
        end
        if (m > SLOTS) return ffra_pkg::STATUS_FULL;
        for (int k = 0; k < m; k++) begin
            hs[k] = ts[k]; he[k] = te[k];
        end
        nholes = m;
        bump = nb;
        return ffra_pkg::STATUS_OK;
    endfunction

    function automatic ffra_pkg::resp_t predict_request(input ffra_pkg::req_t r);
        ffra_pkg::resp_t e;
        e = '0;
        if (r.cmd == ffra_pkg::CMD_ALLOC)
            e.alloc_offset = grant_units(r.unit_count, e.status, e.grew);
        else e.status = release_units(r.free_offset, r.unit_count);
        e.capacity = cap_end;
        e.free_total = free_sum();
        return e;
    endfunction

    // send one request, with an optional random gap first
    task automatic send_request(input logic cmd, input logic [31:0] cnt, input logic [31:0] off);
        ffra_pkg::req_t r;
        if (!quiet && $urandom_range(3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(11, 1)) @(posedge aclk);
        end
        r.cmd = cmd; r.unit_count = cnt; r.free_offset = off;
        s_data <= r;
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        pending_resp = {pending_resp, predict_request(r)};
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (pending_resp.size() != 0) @(posedge aclk);
        repeat (SLOTS * 3 + 10) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] v);
        drain();
        cfg_index <= idx; cfg_wdata <= v; cfg_we <= 1'b1;
        @(posedge aclk);
        cfg_we <= 1'b0;
        case (idx)
            ffra_pkg::CFG_INITIAL_UNITS: begin
                bump = 0; cap_end = v; nholes = 0;
            end
            ffra_pkg::CFG_GROW_MIN_UNITS: grow_min = v;
            default: max_cap = v;
        endcase
    endtask

    // result checker and random receiver stall
    initial begin
        ffra_pkg::resp_t e;
        forever begin
            @(posedge aclk);
            if (m_valid && m_ready) begin
                if (pending_resp.size() == 0) begin
                    report_mismatch("unexpected result", 0, 0);
                end else begin
                    e = pending_resp.pop_front();
                    if (m_data.alloc_offset !== e.alloc_offset)
                        report_mismatch("alloc_offset", m_data.alloc_offset, e.alloc_offset);
                    if (m_data.status !== e.status)
                        report_mismatch("status", 32'(m_data.status), 32'(e.status));
                    if (m_data.grew !== e.grew)
                        report_mismatch("grew", 32'(m_data.grew), 32'(e.grew));
                    if (m_data.capacity !== e.capacity)
                        report_mismatch("capacity", m_data.capacity, e.capacity);
                    if (m_data.free_total !== e.free_total)
                        report_mismatch("free_total", m_data.free_total, e.free_total);
                end
            end
            if (quiet || $urandom_range(4) != 0) m_ready <= 1'b1;
            else begin
                m_ready <= 1'b0;
                repeat ($urandom_range(11, 1)) @(posedge aclk);
                m_ready <= 1'b1;
            end
        end
    end

    task automatic test_edges();
        send_request(ffra_pkg::CMD_ALLOC, 32'd0, 32'hFFFF_FFFF);
        send_request(ffra_pkg::CMD_ALLOC, 32'd100, 32'd0);
        send_request(ffra_pkg::CMD_ALLOC, 32'd100, 32'd0);
        send_request(ffra_pkg::CMD_ALLOC, 32'd100, 32'd0);
        send_request(ffra_pkg::CMD_FREE, 32'd100, 32'd0);
        send_request(ffra_pkg::CMD_FREE, 32'd50, 32'd20);
        send_request(ffra_pkg::CMD_FREE, 32'd0, 32'd0);
        send_request(ffra_pkg::CMD_FREE, 32'd10, 32'd5000);
        send_request(ffra_pkg::CMD_ALLOC, 32'd80, 32'd0);
        send_request(ffra_pkg::CMD_FREE, 32'hFFFF_FFFF, 32'd150);
        send_request(ffra_pkg::CMD_FREE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_request(ffra_pkg::CMD_ALLOC, 32'd70000, 32'd0);
        send_request(ffra_pkg::CMD_ALLOC, 32'hFFFF_FFFF, 32'd0);
        send_request(ffra_pkg::CMD_FREE, 32'd300, 32'd100);
        send_request(ffra_pkg::CMD_FREE, 32'hFFFF_FFFF, 32'd0);
    endtask

    // many small frees to fill the hole table
    task automatic test_table_full();
        write_reg(ffra_pkg::CFG_INITIAL_UNITS, 32'd1000);
        send_request(ffra_pkg::CMD_ALLOC, 32'd200, 32'd0);
        for (int i = 0; i < 18; i++) send_request(ffra_pkg::CMD_FREE, 32'd1, 32'(i * 4));
        send_request(ffra_pkg::CMD_FREE, 32'd3, 32'd1);
        drain();
    endtask

    task automatic test_limits();
        write_reg(ffra_pkg::CFG_GROW_MIN_UNITS, 32'd1);
        write_reg(ffra_pkg::CFG_MAX_UNITS, 32'd1);
        write_reg(ffra_pkg::CFG_INITIAL_UNITS, 32'd0);
        send_request(ffra_pkg::CMD_ALLOC, 32'd1, 32'd0);
        send_request(ffra_pkg::CMD_ALLOC, 32'd1, 32'd0);
        write_reg(ffra_pkg::CFG_MAX_UNITS, 32'hFFFF_FFFF);
        write_reg(ffra_pkg::CFG_GROW_MIN_UNITS, 32'hFFFF_FFFF);
        send_request(ffra_pkg::CMD_ALLOC, 32'd5, 32'd0);
        send_request(ffra_pkg::CMD_ALLOC, 32'd5, 32'd0);
        write_reg(ffra_pkg::CFG_INITIAL_UNITS, 32'hFFFF_FFFF);
        send_request(ffra_pkg::CMD_ALLOC, 32'hFFFF_FFF0, 32'd0);
        send_request(ffra_pkg::CMD_FREE, 32'd7, 32'd3);
    endtask

    task automatic test_random(input int n);
        logic [31:0] c, o;
        for (int i = 0; i < n; i++) begin
            if (i == n / 2) drain();
            if (i == n - 60) quiet = 1'b1;
            if (i % 100 == 0) begin
                write_reg(ffra_pkg::CFG_GROW_MIN_UNITS, 32'($urandom_range(64, 1)));
                write_reg(ffra_pkg::CFG_MAX_UNITS, 32'($urandom_range(4000, 500)));
                write_reg(ffra_pkg::CFG_INITIAL_UNITS, 32'($urandom_range(600, 0)));
            end
            case ($urandom_range(9))
                0: begin c = $urandom; o = $urandom; end
                1, 2, 3, 4: begin c = $urandom_range(40, 0); o = $urandom; end
                default: begin
                    c = $urandom_range(30, 1);
                    o = (bump != 0) ? $urandom_range(bump - 1, 0) : 32'd0;
                end
            endcase
            send_request(($urandom_range(9) < 5) ? ffra_pkg::CMD_ALLOC : ffra_pkg::CMD_FREE,
                         c, o);
        end
    endtask

    initial begin
        grow_min = ffra_pkg::RESET_GROW_MIN; max_cap = ffra_pkg::RESET_MAX_UNITS;
        bump = 0; cap_end = ffra_pkg::RESET_INITIAL_UNITS; nholes = 0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_edges();
        test_table_full();
        test_limits();
        test_random(360);
        drain();
        if (errors == 0) $display("PASSED: all results match");
        else $display("FAILED: results differ");
        $finish;
    end

    initial begin
        #2000000;
        $display("FAILED: results differ");
        $finish;
    end
endmodule

// ===== first_fit_range_allocator_core.f =====
design/ffra_pkg.sv
design/ffra_cell.sv
design/first_fit_range_allocator_core.sv
dv/first_fit_range_allocator_core_test.sv
